// ===== hdl/rrts_pkg.sv =====
// shared types and constants of the round robin thread slot scheduler
package rrts_pkg;

    // per-slot state codes
    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_RUNNING  = 2'd1,
        ST_RUNNABLE = 2'd2
    } slot_state_t;

    // operation codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_CREATE   = 2'd0,
        OP_YIELD    = 2'd1,
        OP_EXIT     = 2'd2,
        OP_SCHEDULE = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_NO_FREE     = 2'd1,
        STAT_NO_RUNNABLE = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_SCAN = 1'b1
    } ctl_state_t;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W       = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_STRIDE = 1'b1;

    localparam int unsigned ADDR_W      = 64;
    localparam int unsigned STRIDE_W    = 16;
    localparam logic [15:0] STRIDE_RESET = 16'd8312;
    localparam logic [ADDR_W-1:0] ALIGN_MASK = ~64'hf;

    localparam int unsigned FIELD_SLOT_W = 2;
    localparam int unsigned M_TDATA_W    = 136;

    // command broadcast from the sequencer to every cell
    typedef struct packed {
        logic        tok_load;   // seed the search token
        logic        tok_shift;  // pass the token to the next cell
        slot_state_t match_st;   // state the search looks for
        logic        wr_en;      // write wr_st into the selected cell
        slot_state_t wr_st;
        logic        save;       // keep the old state with the write
        logic        restore;    // put the kept state back
    } cell_cmd_t;

    // per-cell selects decoded from slot indexes
    typedef struct packed {
        logic seed;
        logic wr;
    } cell_sel_t;

endpackage

// ===== hdl/rrts_cell.sv =====
// one thread slot: state, saved state and search token
module rrts_cell #(
    parameter rrts_pkg::slot_state_t RESET_ST = rrts_pkg::ST_FREE
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rrts_pkg::cell_cmd_t cmd,
    input  rrts_pkg::cell_sel_t sel,
    input  logic                tok_in,
    output logic                tok_out,
    output logic                hit
);

    rrts_pkg::slot_state_t st_reg, st_next;
    rrts_pkg::slot_state_t sav_reg, sav_next;
    logic                  tok_reg, tok_next;

    always_comb
    begin
        st_next  = st_reg;
        sav_next = sav_reg;
        tok_next = tok_reg;
        if (sel.wr && cmd.wr_en)
        begin
            st_next = cmd.wr_st;
            if (cmd.save)
            begin
                sav_next = st_reg;
            end
        end
        else if (sel.wr && cmd.restore)
        begin
            st_next = sav_reg;
        end
        if (cmd.tok_load)
        begin
            tok_next = sel.seed;
        end
        else if (cmd.tok_shift)
        begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= RESET_ST;
            tok_reg <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sav_reg <= sav_next;
    end

    assign tok_out = tok_reg;
    assign hit     = tok_reg && (st_reg == cmd.match_st);

endmodule

// ===== hdl/round_robin_thread_slot_scheduler.sv =====
// top level: slot cell ring, search sequencer, output register and config registers
// operation: an item is accepted while idle, then the search token walks the cell
//   ring one slot a cycle; the result is registered once the token hits or has visited every slot
// throughput: one item at a time, the input is not ready while the token searches;
//   the next item may enter while a result waits
// reset: slot 0 running, other slots free, current slot 0, table_base 0, slot_stride 8312
module round_robin_thread_slot_scheduler #(
    parameter int unsigned NUM_SLOTS   = 4,
    parameter int unsigned STACK_BYTES = 8192
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [63:0]                      s_tdata,   // entry_address
    input  logic [1:0]                       s_tuser,   // op
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[1:0], slot[3:2], previous_slot[5:4], switched[6],
    // start_address[70:7], stack_top[134:71], zero[135]
    output logic [rrts_pkg::M_TDATA_W-1:0]   m_tdata,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rrts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                      cfg_data
);

    localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    // configuration registers
    logic [rrts_pkg::ADDR_W-1:0]   table_base_reg;
    logic [rrts_pkg::STRIDE_W-1:0] slot_stride_reg;

    // sequencer state
    rrts_pkg::ctl_state_t          state_reg, state_next;
    rrts_pkg::op_t                 op_reg, op_next;
    logic [SLOT_W-1:0]             cur_reg, cur_next;      // current slot
    logic [SLOT_W-1:0]             idx_reg, idx_next;      // slot under the token
    logic [SLOT_W-1:0]             cnt_reg, cnt_next;      // search steps taken
    logic [rrts_pkg::ADDR_W-1:0]   entry_reg, entry_next;
    logic [rrts_pkg::ADDR_W-1:0]   addr_reg, addr_next;    // stack end of slot idx_reg

    // output register
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [rrts_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // cell ring
    rrts_pkg::cell_cmd_t           cmd;
    rrts_pkg::cell_sel_t           sel [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]          tok_vec;
    logic [NUM_SLOTS-1:0]          hit_vec;
    logic [SLOT_W-1:0]             seed_idx;
    logic [SLOT_W-1:0]             wr_idx;

    logic                          accept;
    logic                          out_free;
    logic                          found;
    logic                          exhausted;
    logic                          commit;
    logic [SLOT_W-1:0]             cur_inc;
    logic [SLOT_W-1:0]             idx_inc;

    // result fields
    rrts_pkg::status_t             r_status;
    logic [SLOT_W-1:0]             r_slot;
    logic                          r_switched;
    logic [rrts_pkg::ADDR_W-1:0]   r_start;
    logic [rrts_pkg::ADDR_W-1:0]   r_top;
    logic [SLOT_W+1:0]             r_slot_ext;
    logic [SLOT_W+1:0]             r_prev_ext;

    assign s_tready  = (state_reg == rrts_pkg::CTL_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // token hits anywhere in the ring, or it has visited every slot
    assign found     = |hit_vec;
    assign exhausted = (cnt_reg == LAST_IDX);
    assign commit    = (state_reg == rrts_pkg::CTL_SCAN) && (found || exhausted) && out_free;

    assign cur_inc = (cur_reg == LAST_IDX) ? '0 : cur_reg + 1'b1;
    assign idx_inc = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_base_reg  <= '0;
            slot_stride_reg <= rrts_pkg::STRIDE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rrts_pkg::CFG_TABLE_BASE:  table_base_reg  <= cfg_data;
                rrts_pkg::CFG_SLOT_STRIDE: slot_stride_reg <= cfg_data[rrts_pkg::STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer: next state, cell commands and result
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        cur_next      = cur_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        entry_next    = entry_reg;
        addr_next     = addr_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        cmd.tok_load  = 1'b0;
        cmd.tok_shift = 1'b0;
        cmd.match_st  = (op_reg == rrts_pkg::OP_CREATE) ? rrts_pkg::ST_FREE
                                                        : rrts_pkg::ST_RUNNABLE;
        cmd.wr_en     = 1'b0;
        cmd.wr_st     = rrts_pkg::ST_FREE;
        cmd.save      = 1'b0;
        cmd.restore   = 1'b0;
        seed_idx      = cur_inc;
        wr_idx        = cur_reg;

        r_status   = rrts_pkg::STAT_OK;
        r_slot     = idx_reg;
        r_switched = 1'b0;
        r_start    = '0;
        r_top      = '0;
        r_slot_ext = '0;
        r_prev_ext = '0;

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            rrts_pkg::CTL_IDLE:
            begin
                if (accept)
                begin
                    op_next      = rrts_pkg::op_t'(s_tuser);
                    entry_next   = s_tdata;
                    cnt_next     = '0;
                    cmd.tok_load = 1'b1;
                    state_next   = rrts_pkg::CTL_SCAN;
                    if (rrts_pkg::op_t'(s_tuser) == rrts_pkg::OP_CREATE)
                    begin
                        // lowest free slot: search from slot 0 upward
                        seed_idx  = '0;
                        idx_next  = '0;
                        addr_next = table_base_reg + rrts_pkg::ADDR_W'(STACK_BYTES);
                    end
                    else
                    begin
                        // round robin from the slot after the current one
                        seed_idx = cur_inc;
                        idx_next = cur_inc;
                        // yield and exit remark the current slot first, keeping the old mark
                        if (rrts_pkg::op_t'(s_tuser) == rrts_pkg::OP_YIELD)
                        begin
                            cmd.wr_en = 1'b1;
                            cmd.wr_st = rrts_pkg::ST_RUNNABLE;
                            cmd.save  = 1'b1;
                        end
                        else if (rrts_pkg::op_t'(s_tuser) == rrts_pkg::OP_EXIT)
                        begin
                            cmd.wr_en = 1'b1;
                            cmd.wr_st = rrts_pkg::ST_FREE;
                            cmd.save  = 1'b1;
                        end
                    end
                end
            end

            rrts_pkg::CTL_SCAN:
            begin
                if (commit)
                begin
                    state_next    = rrts_pkg::CTL_IDLE;
                    m_tvalid_next = 1'b1;
                    if (op_reg == rrts_pkg::OP_CREATE)
                    begin
                        if (found)
                        begin
                            wr_idx    = idx_reg;
                            cmd.wr_en = 1'b1;
                            cmd.wr_st = rrts_pkg::ST_RUNNABLE;
                            r_slot    = idx_reg;
                            r_start   = entry_reg;
                            r_top     = addr_reg & rrts_pkg::ALIGN_MASK;
                        end
                        else
                        begin
                            r_status = rrts_pkg::STAT_NO_FREE;
                            r_slot   = '0;
                        end
                    end
                    else if (found)
                    begin
                        r_slot = idx_reg;
                        // search came back to the current slot: no switch, mark kept
                        if (idx_reg != cur_reg)
                        begin
                            wr_idx     = idx_reg;
                            cmd.wr_en  = 1'b1;
                            cmd.wr_st  = rrts_pkg::ST_RUNNING;
                            cur_next   = idx_reg;
                            r_switched = 1'b1;
                        end
                    end
                    else
                    begin
                        // nothing runnable: undo the remark of yield or exit
                        r_status    = rrts_pkg::STAT_NO_RUNNABLE;
                        r_slot      = cur_reg;
                        wr_idx      = cur_reg;
                        cmd.restore = (op_reg == rrts_pkg::OP_YIELD) ||
                                      (op_reg == rrts_pkg::OP_EXIT);
                    end
                    r_slot_ext   = (SLOT_W + 2)'(r_slot);
                    r_prev_ext   = (SLOT_W + 2)'(cur_reg);
                    m_tdata_next = {1'b0, r_top, r_start, r_switched,
                                    r_prev_ext[rrts_pkg::FIELD_SLOT_W-1:0],
                                    r_slot_ext[rrts_pkg::FIELD_SLOT_W-1:0],
                                    r_status};
                end
                else if (!found && !exhausted)
                begin
                    // token moves on one slot, stack end follows it
                    cmd.tok_shift = 1'b1;
                    idx_next      = idx_inc;
                    cnt_next      = cnt_reg + 1'b1;
                    addr_next     = addr_reg + rrts_pkg::ADDR_W'(slot_stride_reg);
                end
            end

            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rrts_pkg::CTL_IDLE;
            cur_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        entry_reg   <= entry_next;
        addr_reg    <= addr_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ring of slot cells; the token runs from cell i to cell i+1 and wraps
    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        localparam rrts_pkg::slot_state_t RST_ST = (i == 0) ? rrts_pkg::ST_RUNNING
                                                           : rrts_pkg::ST_FREE;

        assign sel[i].seed = (seed_idx == SLOT_W'(i));
        assign sel[i].wr   = (wr_idx == SLOT_W'(i));

        rrts_cell #(
            .RESET_ST (RST_ST)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .sel     (sel[i]),
            .tok_in  (tok_vec[(i + NUM_SLOTS - 1) % NUM_SLOTS]),
            .tok_out (tok_vec[i]),
            .hit     (hit_vec[i])
        );
    end

endmodule

// ===== hdl/rrts_checker.sv =====
// port-level checks of the scheduler's result stream
module rrts_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rrts_pkg::M_TDATA_W-1:0] m_tdata
);

    // a held result keeps its data
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // status is one of the three codes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == rrts_pkg::STAT_OK) ||
                     (m_tdata[1:0] == rrts_pkg::STAT_NO_FREE) ||
                     (m_tdata[1:0] == rrts_pkg::STAT_NO_RUNNABLE))
        else $error("bad status code");

    // a failed operation never switches
    a_fail_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != rrts_pkg::STAT_OK |-> !m_tdata[6])
        else $error("switch reported on failure");

    // no runnable slot keeps the current slot
    a_norun_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == rrts_pkg::STAT_NO_RUNNABLE |-> m_tdata[3:2] == m_tdata[5:4])
        else $error("slot moved without a runnable slot");

    // stack top always 16-byte aligned
    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[74:71] == 4'd0)
        else $error("stack top not aligned");

endmodule

bind round_robin_thread_slot_scheduler rrts_checker u_rrts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/round_robin_thread_slot_scheduler_tb.sv =====
// self-checking testbench for the round robin thread slot scheduler
module round_robin_thread_slot_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_SLOTS   = 4;
    localparam int unsigned STACK_BYTES = 8192;
    // settling wait after draining, sized from the ring length plus margin
    localparam int unsigned DRAIN_WAIT  = NUM_SLOTS + 4;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_ITEMS = 230;

    // one input item waiting to be offered
    typedef struct {
        rrts_pkg::op_t op;
        logic [63:0]   entry;
    } sched_op_t;

    // one predicted result item
    typedef struct {
        rrts_pkg::status_t status;
        logic [1:0]        slot;
        logic [1:0]        prev;
        logic              switched;
        logic [63:0]       start_address;
        logic [63:0]       stack_top;
    } sched_result_t;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [63:0]                     s_tdata   = '0;
    rrts_pkg::op_t                   s_tuser   = rrts_pkg::OP_CREATE;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [rrts_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [rrts_pkg::CFG_IDX_W-1:0]  cfg_index = rrts_pkg::CFG_TABLE_BASE;
    logic [63:0]                     cfg_data  = '0;

    // scheduler image kept by the testbench
    rrts_pkg::slot_state_t slot_marks [NUM_SLOTS];
    int unsigned           cur_slot;
    logic [63:0]           stack_base;
    logic [15:0]           stack_stride;

    sched_op_t             ops_to_send [$];
    sched_result_t         results_due [$];

    int unsigned           send_idle_pct = 0;
    int unsigned           stall_pct     = 0;
    int unsigned           hold_requests = 0;
    int unsigned           hold_served   = 0;
    int unsigned           hold_left     = 0;
    int unsigned           mismatches    = 0;
    int unsigned           cycles        = 0;

    round_robin_thread_slot_scheduler #(
        .NUM_SLOTS   (NUM_SLOTS),
        .STACK_BYTES (STACK_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // reset image: slot 0 running, others free, default stride
    initial
    begin : image_reset
        int unsigned k;
        for (k = 0; k < NUM_SLOTS; k++)
            slot_marks[k] = rrts_pkg::ST_FREE;
        slot_marks[0] = rrts_pkg::ST_RUNNING;
        cur_slot      = 0;
        stack_base    = '0;
        stack_stride  = rrts_pkg::STRIDE_RESET;
    end

    // one line per mismatch, counted for the final verdict
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatches++;
    endtask

    // apply one accepted item to the image and queue the result it causes
    task automatic advance_scheduler(input rrts_pkg::op_t op, input logic [63:0] entry);
        sched_result_t         r;
        int unsigned           k;
        int unsigned           idx;
        int unsigned           found;
        rrts_pkg::slot_state_t kept;
        r = '{rrts_pkg::STAT_OK, 2'd0, 2'(cur_slot), 1'b0, 64'd0, 64'd0};
        found = NUM_SLOTS;
        if (op == rrts_pkg::OP_CREATE)
        begin
            // lowest free slot wins
            for (k = 0; k < NUM_SLOTS; k++)
                if (found == NUM_SLOTS && slot_marks[k] == rrts_pkg::ST_FREE)
                    found = k;
            if (found == NUM_SLOTS)
                r.status = rrts_pkg::STAT_NO_FREE;
            else
            begin
                slot_marks[found] = rrts_pkg::ST_RUNNABLE;
                r.slot            = 2'(found);
                r.start_address   = entry;
                // stack end wraps modulo 2^64, then aligned down to 16 bytes
                r.stack_top = (stack_base + 64'(found) * 64'(stack_stride)
                               + 64'(STACK_BYTES)) & ~64'hf;
            end
        end
        else
        begin
            kept = slot_marks[cur_slot];
            if (op == rrts_pkg::OP_YIELD)
                slot_marks[cur_slot] = rrts_pkg::ST_RUNNABLE;
            else if (op == rrts_pkg::OP_EXIT)
                slot_marks[cur_slot] = rrts_pkg::ST_FREE;
            // round robin from current+1, ending at current
            idx = cur_slot;
            for (k = 0; k < NUM_SLOTS; k++)
            begin
                idx = (idx + 1) % NUM_SLOTS;
                if (found == NUM_SLOTS && slot_marks[idx] == rrts_pkg::ST_RUNNABLE)
                    found = idx;
            end
            if (found == NUM_SLOTS)
            begin
                // nothing runnable: undo the mark, stay put
                slot_marks[cur_slot] = kept;
                r.status             = rrts_pkg::STAT_NO_RUNNABLE;
                r.slot               = 2'(cur_slot);
            end
            else if (found != cur_slot)
            begin
                slot_marks[found] = rrts_pkg::ST_RUNNING;
                cur_slot          = found;
                r.slot            = 2'(found);
                r.switched        = 1'b1;
            end
            else
                r.slot = 2'(found);   // found itself, keeps its runnable mark
        end
        results_due.push_back(r);
    endtask

    // sender: holds an offered item until taken, idles at random between items
    always @(posedge clk)
    begin : sender
        sched_op_t nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                advance_scheduler(s_tuser, s_tdata);
            if (!(s_tvalid && !s_tready))
            begin
                if (ops_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = ops_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.entry;
                    s_tuser  <= nxt.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here so the sender keeps pushing
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_served != hold_requests)
        begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
    end

    // receiver: check each taken result against the oldest prediction
    always @(posedge clk)
    begin : receiver
        sched_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("unexpected item", m_tdata[63:0], 64'd0);
                else
                begin
                    want = results_due.pop_front();
                    if (m_tdata[1:0] != want.status)
                        report_mismatch("status", m_tdata[1:0], want.status);
                    if (m_tdata[3:2] != want.slot)
                        report_mismatch("slot", m_tdata[3:2], want.slot);
                    if (m_tdata[5:4] != want.prev)
                        report_mismatch("previous_slot", m_tdata[5:4], want.prev);
                    if (m_tdata[6] != want.switched)
                        report_mismatch("switched", m_tdata[6], want.switched);
                    if (m_tdata[70:7] != want.start_address)
                        report_mismatch("start_address", m_tdata[70:7],
                                        want.start_address);
                    if (m_tdata[134:71] != want.stack_top)
                        report_mismatch("stack_top", m_tdata[134:71], want.stack_top);
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic queue_op(input rrts_pkg::op_t op, input logic [63:0] entry);
        sched_op_t it;
        it.op    = op;
        it.entry = entry;
        ops_to_send.push_back(it);
    endtask

    // wait until every item is sent and answered, then let the ring settle
    // sampled between edges so the sender's updates are settled
    task automatic wait_drained();
        @(negedge clk);
        while (ops_to_send.size() != 0 || s_tvalid || results_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // register write while the block is idle; image follows on the handshake
    task automatic write_reg(input logic [rrts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == rrts_pkg::CFG_TABLE_BASE)
            stack_base = val;
        else
            stack_stride = val[15:0];
    endtask

    // random mix: creates refill the table, exits drain it
    task automatic queue_random_ops(input int unsigned count);
        int unsigned   n;
        int unsigned   pick;
        rrts_pkg::op_t op;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                op = rrts_pkg::OP_CREATE;
            else if (pick < 55)
                op = rrts_pkg::OP_YIELD;
            else if (pick < 75)
                op = rrts_pkg::OP_EXIT;
            else
                op = rrts_pkg::OP_SCHEDULE;
            queue_op(op, {$urandom, $urandom});
        end
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall,
                             input bit squeeze);
        @(posedge clk);
        send_idle_pct <= idle_pct;
        stall_pct     <= stall;
        queue_random_ops(PHASE_ITEMS);
        if (squeeze)
            hold_requests <= hold_requests + 1;
        wait_drained();
    endtask

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk at reset config
        queue_op(rrts_pkg::OP_SCHEDULE, 64'd0);                    // nothing runnable
        queue_op(rrts_pkg::OP_EXIT,     64'd0);                    // exit with nothing to run
        queue_op(rrts_pkg::OP_YIELD,    64'd0);                    // search finds current
        queue_op(rrts_pkg::OP_SCHEDULE, 64'd0);                    // current stays runnable
        queue_op(rrts_pkg::OP_CREATE,   64'd0);
        queue_op(rrts_pkg::OP_CREATE,   64'hffff_ffff_ffff_ffff);
        queue_op(rrts_pkg::OP_CREATE,   64'h5555_5555_5555_5555);
        queue_op(rrts_pkg::OP_CREATE,   64'haaaa_aaaa_aaaa_aaaa);  // table full
        queue_op(rrts_pkg::OP_SCHEDULE, 64'd0);                    // switch to slot 1
        queue_op(rrts_pkg::OP_YIELD,    64'd0);
        queue_op(rrts_pkg::OP_EXIT,     64'd0);
        queue_op(rrts_pkg::OP_EXIT,     64'd0);                    // wraps back to slot 0
        queue_op(rrts_pkg::OP_CREATE,   64'h0123_4567_89ab_cdef);
        queue_op(rrts_pkg::OP_YIELD,    64'd0);
        queue_op(rrts_pkg::OP_EXIT,     64'd0);
        queue_op(rrts_pkg::OP_EXIT,     64'd0);
        queue_op(rrts_pkg::OP_EXIT,     64'd0);                    // last thread, exit refused
        wait_drained();

        // top of address space, widest stride: stack top wraps
        write_reg(rrts_pkg::CFG_TABLE_BASE,  64'hffff_ffff_ffff_ffff);
        write_reg(rrts_pkg::CFG_SLOT_STRIDE, 64'(16'hffff));
        queue_op(rrts_pkg::OP_CREATE, 64'hdead_beef_0000_0001);
        queue_op(rrts_pkg::OP_CREATE, 64'h8000_0000_0000_0000);
        queue_op(rrts_pkg::OP_CREATE, 64'h0000_0000_ffff_ffff);
        run_phase(0, 0, 1'b0);

        // bottom of address space, narrowest stride, sender idling
        write_reg(rrts_pkg::CFG_TABLE_BASE,  64'd0);
        write_reg(rrts_pkg::CFG_SLOT_STRIDE, 64'(16'd8192));
        run_phase(64, 0, 1'b0);

        // random settings, receiver stalling
        write_reg(rrts_pkg::CFG_TABLE_BASE,  {$urandom, $urandom});
        write_reg(rrts_pkg::CFG_SLOT_STRIDE, 64'($urandom_range(65535, 8192)));
        run_phase(0, 64, 1'b0);

        write_reg(rrts_pkg::CFG_TABLE_BASE,  {$urandom, $urandom});
        write_reg(rrts_pkg::CFG_SLOT_STRIDE, 64'($urandom_range(65535, 8192)));
        run_phase(25, 25, 1'b0);

        // back-pressure: receiver holds off while the sender keeps offering
        write_reg(rrts_pkg::CFG_TABLE_BASE,  {$urandom, $urandom});
        write_reg(rrts_pkg::CFG_SLOT_STRIDE, 64'($urandom_range(65535, 8192)));
        run_phase(0, 0, 1'b1);

        if (mismatches == 0 && results_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
